// ===== design/shf_pkg.sv =====
// shared types, constants and mix helpers for the simhash fingerprint block
// used by every module under design/
`timescale 1ns / 1ps
`default_nettype none

package shf_pkg;

  localparam int unsigned MAX_TEXT_LEN = 65536;
  // vote counters must hold +/-MAX_TEXT_LEN as signed values
  localparam int unsigned VOTE_W = $clog2(MAX_TEXT_LEN + 1) + 1;

  localparam int unsigned HASH_W = 64;
  localparam int unsigned HALF_W = HASH_W / 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PAIR_W = 2 * BYTE_W;
  localparam int unsigned ROT_SH = 31;
  localparam int unsigned FOLD_SH = 33;

  localparam logic signed [VOTE_W-1:0] VOTE_MAX = VOTE_W'(MAX_TEXT_LEN);
  localparam logic signed [VOTE_W-1:0] VOTE_MIN = -VOTE_MAX;
  localparam logic signed [VOTE_W-1:0] VOTE_ONE = VOTE_W'(1);

  localparam logic [HASH_W-1:0] MIX_C1 = 64'hC6A4A7935BD1E995;
  localparam logic [HASH_W-1:0] MIX_C2 = 64'hFF51AFD7ED558CCD;
  localparam logic [HASH_W-1:0] MIX_C3 = 64'hC4CEB9FE1A85EC53;
  localparam logic [HASH_W-1:0] MIX_C1_X2 = MIX_C1 << 1;
  localparam logic [HASH_W-1:0] MIX_C1_X3 = MIX_C1_X2 + MIX_C1;
  localparam logic [HASH_W-1:0] SEED_RESET = 64'd42;

  // window length codes
  localparam logic [1:0] LEN_ONE = 2'd1;
  localparam logic [1:0] LEN_TWO = 2'd2;
  localparam logic [1:0] LEN_FULL = 2'd3;

  // job queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic              last;
    logic [1:0]        len;
    logic [PAIR_W-1:0] pair;
    logic [BYTE_W-1:0] tail_byte;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] p;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_VOTE,
    ST_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    PH_PAIR,
    PH_PROT,
    PH_TAIL,
    PH_TROT,
    PH_FIN2,
    PH_FIN3
  } mix_phase_t;

  function automatic logic [HASH_W-1:0] rotl31(input logic [HASH_W-1:0] x);
    return (x << ROT_SH) | (x >> (HASH_W - ROT_SH));
  endfunction

  function automatic logic [HASH_W-1:0] fold33(input logic [HASH_W-1:0] x);
    return x ^ (x >> FOLD_SH);
  endfunction

  // len * C1 mod 2^64
  function automatic logic [HASH_W-1:0] len_c1(input logic [1:0] len);
    logic [HASH_W-1:0] r;
    unique case (len)
      LEN_ONE:  r = MIX_C1;
      LEN_TWO:  r = MIX_C1_X2;
      LEN_FULL: r = MIX_C1_X3;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/simhash_fingerprint_3gram.sv =====
// SimHash fingerprint over byte trigrams: one text byte per item, one 64-bit fingerprint
// per text on the item flagged end_of_text. Top level: seed register, front, queue, back.
// Depends on shf_pkg, shf_front, shf_queue, shf_back.
//
// The front takes a byte every cycle while its 4-entry job queue has room; the first two
// bytes of a text make no job. Each job (one per byte from the third on, or the whole text
// when it ends after one or two bytes) runs through the mix on a single shared 32x32
// multiplier: 6 multiplies for a trigram and 4 for a short text. That multiplier sets the
// sustained rate. The fingerprint sits in an output register, so the back end takes the next
// text while it waits. Vote counters saturate at +/-65536. hash_seed resets to 42 and must be
// written through cfg_* while idle by the user; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module simhash_fingerprint_3gram import shf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_text_byte,
  input  wire logic              in_end_of_text,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [HASH_W-1:0]      out_fingerprint,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [HASH_W-1:0] cfg_hash_seed
);

  logic [HASH_W-1:0] seed_r;
  logic              q_full;
  logic              q_nonempty;
  logic              job_push;
  logic              job_pop;
  job_t              push_job;
  job_t              head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) seed_r <= SEED_RESET;
    else if (cfg_valid && cfg_ready) seed_r <= cfg_hash_seed;
  end

  shf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .job_push       (job_push),
    .job            (push_job)
  );

  shf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  shf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .seed            (seed_r),
    .job_valid       (q_nonempty),
    .job             (head_job),
    .job_pop         (job_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_fingerprint (out_fingerprint)
  );

endmodule

`default_nettype wire

// ===== design/shf_queue.sv =====
// short job queue between the byte front end and the hash back end
// depends on shf_pkg (job_t, queue depth)
`timescale 1ns / 1ps
`default_nettype none

module shf_queue import shf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output logic      full,
  output logic      nonempty
);

  job_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign nonempty = (count_r != '0);
  assign head_job = slots_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop) count_r <= count_r + QCNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

// ===== design/shf_front.sv =====
// front end: takes text bytes, tracks the trigram window and queues hash jobs
// depends on shf_pkg
`timescale 1ns / 1ps
`default_nettype none

module shf_front import shf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_text_byte,
  input  wire logic              in_end_of_text,
  input  wire logic              q_full,
  output logic                   job_push,
  output job_t                   job
);

  logic [PAIR_W-1:0] window_r;
  logic [PAIR_W-1:0] window_nxt;
  logic [1:0]        seen_r;
  logic [1:0]        seen_nxt;
  logic [1:0]        len;
  logic              accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign len      = (seen_r == LEN_FULL) ? LEN_FULL : seen_r + 2'd1;

  always_comb begin
    job.last      = in_end_of_text;
    job.len       = len;
    job.tail_byte = in_text_byte;
    // pair is b0 | b1 << 8
    if (len == LEN_FULL) job.pair = {window_r[BYTE_W-1:0], window_r[PAIR_W-1:BYTE_W]};
    else                 job.pair = {in_text_byte, window_r[BYTE_W-1:0]};
  end

  // short texts are hashed only at their last byte
  assign job_push = accept && (len == LEN_FULL || in_end_of_text);

  always_comb begin
    window_nxt = window_r;
    seen_nxt   = seen_r;
    if (accept) begin
      if (in_end_of_text) begin
        window_nxt = '0;
        seen_nxt   = '0;
      end else begin
        window_nxt = {window_r[BYTE_W-1:0], in_text_byte};
        seen_nxt   = len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
    end else begin
      window_r <= window_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/shf_mul.sv =====
// 64x64 mod 2^64 multiplier built from one 32x32 multiplier
// depends on shf_pkg (mul_req_t, mul_rsp_t)
`timescale 1ns / 1ps
`default_nettype none

module shf_mul import shf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic [HASH_W-1:0] a_r;
  logic [HASH_W-1:0] b_r;
  logic [HASH_W-1:0] prod_r;
  logic [HASH_W-1:0] prod_nxt;
  logic [HASH_W-1:0] acc_r;
  logic [1:0]        step_r;
  logic              busy_r;
  logic              done_r;
  logic [HALF_W-1:0] op_x;
  logic [HALF_W-1:0] op_y;
  logic              launch;

  assign launch = req.start && !busy_r;

  // lo*lo, then the two cross terms, whose low halves land in the upper word
  always_comb begin
    unique case (step_r)
      2'd1: begin
        op_x = a_r[HALF_W-1:0];
        op_y = b_r[HASH_W-1:HALF_W];
      end
      2'd2: begin
        op_x = a_r[HASH_W-1:HALF_W];
        op_y = b_r[HALF_W-1:0];
      end
      default: begin
        op_x = a_r[HALF_W-1:0];
        op_y = b_r[HALF_W-1:0];
      end
    endcase
    prod_nxt = HASH_W'(op_x) * HASH_W'(op_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (launch) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (busy_r) begin
      prod_r <= prod_nxt;
      if (step_r == 2'd1) acc_r <= prod_r;
      else if (step_r != 2'd0) acc_r <= acc_r + {prod_r[HALF_W-1:0], HALF_W'(0)};
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

`default_nettype wire

// ===== design/shf_back.sv =====
// back end: runs the multiply-rotate mix per job, votes the 64 counters, emits fingerprints
// depends on shf_pkg and shf_mul
`timescale 1ns / 1ps
`default_nettype none

module shf_back import shf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [HASH_W-1:0] seed,
  input  wire logic              job_valid,
  input  wire job_t              job,
  output logic                   job_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [HASH_W-1:0]      out_fingerprint
);

  back_state_t state_r, state_nxt;
  mix_phase_t  phase_r, phase_nxt;
  job_t        job_r;
  logic [HASH_W-1:0] h_r;
  logic [HASH_W-1:0] h_nxt;
  logic signed [VOTE_W-1:0] votes_r [HASH_W];
  logic [HASH_W-1:0] fp;
  logic              out_valid_r;
  logic [HASH_W-1:0] out_fp_r;
  logic              out_free;
  logic              vote_en;
  logic              emit_en;
  logic              mul_start;
  mul_req_t          mreq;
  mul_rsp_t          mrsp;

  shf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (job_valid) state_nxt = ST_ISSUE;
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT:  if (mrsp.done) state_nxt = (phase_r == PH_FIN3) ? ST_VOTE : ST_ISSUE;
      ST_VOTE:  state_nxt = job_r.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    job_pop   = 1'b0;
    mul_start = 1'b0;
    vote_en   = 1'b0;
    emit_en   = 1'b0;
    unique case (state_r)
      ST_IDLE:  job_pop = job_valid;
      ST_ISSUE: mul_start = 1'b1;
      ST_VOTE:  vote_en = 1'b1;
      ST_EMIT:  emit_en = out_free;
      default:  ;
    endcase
  end

  // multiplier operands per mix phase
  always_comb begin
    mreq.start = mul_start;
    unique case (phase_r)
      PH_PAIR: begin
        mreq.a = HASH_W'(job_r.pair);
        mreq.b = MIX_C1;
      end
      PH_TAIL: begin
        mreq.a = HASH_W'(job_r.tail_byte);
        mreq.b = MIX_C1;
      end
      PH_PROT, PH_TROT: begin
        mreq.a = rotl31(h_r);
        mreq.b = MIX_C1;
      end
      PH_FIN2: begin
        mreq.a = fold33(h_r);
        mreq.b = MIX_C2;
      end
      PH_FIN3: begin
        mreq.a = fold33(h_r);
        mreq.b = MIX_C3;
      end
      default: begin
        mreq.a = h_r;
        mreq.b = MIX_C1;
      end
    endcase
  end

  // hash word and phase
  always_comb begin
    h_nxt     = h_r;
    phase_nxt = phase_r;
    if (state_r == ST_IDLE && job_valid) begin
      h_nxt     = seed ^ len_c1(job.len);
      phase_nxt = job.len[1] ? PH_PAIR : PH_TAIL;
    end else if (state_r == ST_WAIT && mrsp.done) begin
      unique case (phase_r)
        PH_PAIR: begin
          h_nxt     = h_r ^ mrsp.p;
          phase_nxt = PH_PROT;
        end
        PH_PROT: begin
          h_nxt     = mrsp.p;
          phase_nxt = job_r.len[0] ? PH_TAIL : PH_FIN2;
        end
        PH_TAIL: begin
          h_nxt     = h_r ^ mrsp.p;
          phase_nxt = PH_TROT;
        end
        PH_TROT: begin
          h_nxt     = mrsp.p;
          phase_nxt = PH_FIN2;
        end
        PH_FIN2: begin
          h_nxt     = mrsp.p;
          phase_nxt = PH_FIN3;
        end
        PH_FIN3: h_nxt = fold33(mrsp.p);
        default: phase_nxt = PH_PAIR;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < HASH_W; i++) begin
      fp[i] = !votes_r[i][VOTE_W-1] && (votes_r[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_PAIR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (emit_en) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    if (job_pop) job_r <= job;
    if (emit_en) out_fp_r <= fp;
  end

  // saturating vote counters, cleared once the fingerprint is loaded into the output register
  always_ff @(posedge clk) begin
    if (!rst_n || emit_en) begin
      for (int i = 0; i < HASH_W; i++) votes_r[i] <= '0;
    end else if (vote_en) begin
      for (int i = 0; i < HASH_W; i++) begin
        if (h_r[i]) begin
          if (votes_r[i] != VOTE_MAX) votes_r[i] <= votes_r[i] + VOTE_ONE;
        end else begin
          if (votes_r[i] != VOTE_MIN) votes_r[i] <= votes_r[i] - VOTE_ONE;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fingerprint = out_fp_r;

endmodule

`default_nettype wire
